### design/sipq_pkg.sv
// Shared types, codes and the compare function of the sorted-insert priority queue.
`default_nettype none
package sipq_pkg;

  // One stored task record
  typedef struct packed {
    logic [15:0] stamp;
    logic [7:0]  urg;
    logic [15:0] svc;
  } rec_t;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Ordering modes
  localparam logic MODE_URGENCY = 1'b0;
  localparam logic MODE_STAMP   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic cmp_en;
    logic done;
  } ctrl_t;

  // True when the new record moves past the stored one
  function automatic logic rec_passes(input logic mode, input rec_t nw, input rec_t old);
    logic res;
    if (mode == MODE_STAMP) begin
      res = (nw.stamp < old.stamp);
    end else begin
      res = (nw.urg < old.urg) || ((nw.urg == old.urg) && (nw.stamp < old.stamp));
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### design/sipq_cell.sv
// One queue cell: holds a record, compares it with the new one and shifts.
`default_nettype none
module sipq_cell (
  input  wire logic          clk,
  input  wire logic          cmp_en,
  input  wire logic          upd_en,
  input  wire logic          op_remove,
  input  wire logic          order_mode,
  input  wire logic          occupied,
  input  wire logic          allpass_in,
  input  wire sipq_pkg::rec_t new_rec,
  input  wire sipq_pkg::rec_t prev_rec,
  input  wire sipq_pkg::rec_t next_rec,
  output logic               allpass_out,
  output sipq_pkg::rec_t     rec
);

  sipq_pkg::rec_t rec_r;
  sipq_pkg::rec_t rec_nxt;
  logic           pass_r;

  // Compare the new record against the stored one; empty cells stop the scan
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      pass_r <= occupied & sipq_pkg::rec_passes(order_mode, new_rec, rec_r);
    end
    if (upd_en) begin
      rec_r <= rec_nxt;
    end
  end

  // Scan chain: this cell and every cell before it were passed
  assign allpass_out = allpass_in & pass_r;

  // Pick the next record: keep, take the new one, or shift from a neighbor
  always_comb begin
    if (op_remove) begin
      rec_nxt = next_rec;
    end else if (!allpass_in) begin
      rec_nxt = prev_rec;
    end else if (pass_r) begin
      rec_nxt = rec_r;
    end else begin
      rec_nxt = new_rec;
    end
  end

  assign rec = rec_r;

endmodule
`default_nettype wire

### design/sipq_ctrl.sv
// Request sequencer: accept, compare, then update and issue the result.
`default_nettype none
module sipq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          out_free,
  output sipq_pkg::ctrl_t    ctrl
);

  sipq_pkg::state_t state_r;
  sipq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sipq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the sequence; hold in update until the result register is free
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sipq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sipq_pkg::S_CMP;
      end
      sipq_pkg::S_CMP: begin
        state_nxt = sipq_pkg::S_UPD;
      end
      sipq_pkg::S_UPD: begin
        if (out_free) state_nxt = sipq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sipq_pkg::S_IDLE;
      end
    endcase
  end

  // Drive the strobes
  always_comb begin
    ctrl = '0;
    case (state_r)
      sipq_pkg::S_IDLE: ctrl.in_ready = 1'b1;
      sipq_pkg::S_CMP:  ctrl.cmp_en   = 1'b1;
      sipq_pkg::S_UPD:  ctrl.done     = out_free;
      default:          ctrl          = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/sorted_insert_priority_queue.sv
// Top level of the sorted-insert priority queue: cell row, sequencer, result register.
//
// Usage:
//   Input channel (in_*): one request per transaction. in_req_type 0 inserts the
//   record (stamp, urgency, service length), 1 removes the head record.
//   Result channel (out_*): one result per request with status, the removed record
//   (zero unless a successful remove) and the occupancy after the request.
//   Config channel (cfg_*): writes order_mode; always ready, write only while idle.
// Sequence:
//   After a request is accepted, the compare step registers every cell's verdict,
//   then the update step resolves the first stopping cell along the row and shifts.
//   The next request is not taken until the update step has issued the result.
// Stall:
//   The next request is taken while a result waits in the output register; if that
//   register is still full at the update step, the row holds until it drains.
// Reset:
//   Clears the record count, the sequencer, the result valid and order_mode.
//   Cell contents are not cleared; only cells below the count are ever used.
`default_nettype none
module sorted_insert_priority_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [15:0] in_arrival_stamp,
  input  wire logic [7:0]  in_urgency,
  input  wire logic [15:0] in_service_length,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_arrival_stamp,
  output logic [7:0]       out_urgency,
  output logic [15:0]      out_service_length,
  output logic [6:0]       out_occupancy,
  // Config channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_order_mode
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

  sipq_pkg::ctrl_t ctrl;
  logic            out_free;

  logic            order_mode_r;
  logic            req_r;
  sipq_pkg::rec_t  new_rec_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  logic            ins_ok;
  logic            rem_ok;
  logic            cell_upd;
  logic [1:0]      status_nxt;
  logic [CW+6:0]   count_wide;

  sipq_pkg::rec_t  cell_rec [QUEUE_DEPTH];
  logic            allpass [QUEUE_DEPTH+1];

  logic            out_valid_r;
  logic [1:0]      out_status_r;
  sipq_pkg::rec_t  out_rec_r;
  logic [6:0]      out_occ_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = ctrl.in_ready;

  // Sequencer
  sipq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= sipq_pkg::MODE_URGENCY;
    end else if (cfg_valid && cfg_ready) begin
      order_mode_r <= cfg_order_mode;
    end
  end

  // Capture the request on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && ctrl.in_ready) begin
      req_r           <= in_req_type;
      new_rec_r.stamp <= in_arrival_stamp;
      new_rec_r.urg   <= in_urgency;
      new_rec_r.svc   <= in_service_length;
    end
  end

  // Decide whether the request changes the queue
  assign ins_ok   = (req_r == sipq_pkg::REQ_INSERT) && (count_r != DEPTH_CNT);
  assign rem_ok   = (req_r == sipq_pkg::REQ_REMOVE) && (count_r != '0);
  assign cell_upd = ctrl.done && (ins_ok || rem_ok);

  always_comb begin
    count_nxt  = count_r;
    status_nxt = sipq_pkg::ST_OK;
    if (ins_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (rem_ok) begin
      count_nxt = count_r - 1'b1;
    end else if (req_r == sipq_pkg::REQ_INSERT) begin
      status_nxt = sipq_pkg::ST_FULL;
    end else begin
      status_nxt = sipq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.done) begin
      count_r <= count_nxt;
    end
  end

  // Row of cells; the scan chain starts passed at the head
  assign allpass[0] = 1'b1;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    sipq_pkg::rec_t prev_rec;
    sipq_pkg::rec_t next_rec;

    if (i == 0) begin : g_head
      assign prev_rec = new_rec_r;
    end else begin : g_body
      assign prev_rec = cell_rec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_rec = cell_rec[i];
    end else begin : g_inner
      assign next_rec = cell_rec[i+1];
    end

    sipq_cell u_cell (
      .clk         (clk),
      .cmp_en      (ctrl.cmp_en),
      .upd_en      (cell_upd),
      .op_remove   (req_r),
      .order_mode  (order_mode_r),
      .occupied    (IDX < count_r),
      .allpass_in  (allpass[i]),
      .new_rec     (new_rec_r),
      .prev_rec    (prev_rec),
      .next_rec    (next_rec),
      .allpass_out (allpass[i+1]),
      .rec         (cell_rec[i])
    );
  end

  // Occupancy shows the low seven bits of the count
  assign count_wide = {7'b0, count_nxt};

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      out_status_r <= status_nxt;
      out_rec_r    <= rem_ok ? cell_rec[0] : '0;
      out_occ_r    <= count_wide[6:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_arrival_stamp  = out_rec_r.stamp;
  assign out_urgency        = out_rec_r.urg;
  assign out_service_length = out_rec_r.svc;
  assign out_occupancy      = out_occ_r;

endmodule
`default_nettype wire

### design/sipq_checker.sv
// Port-level checker for the sorted-insert priority queue, with its bind.
`default_nettype none
module sipq_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_arrival_stamp,
  input wire logic [7:0]  out_urgency,
  input wire logic [15:0] out_service_length,
  input wire logic [6:0]  out_occupancy
);

  localparam int  OCC_W  = 32;
  localparam logic [OCC_W-1:0] FULL_CNT = OCC_W'(QUEUE_DEPTH);

  // Stalled result holds its status, stamp and occupancy
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_arrival_stamp) && $stable(out_occupancy))
    else $error("result changed while stalled");

  // Busy right after a request transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on back-to-back cycles");

  // A failed request carries a zero record
  a_zero_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != sipq_pkg::ST_OK) |->
      (out_arrival_stamp == '0) && (out_urgency == '0) && (out_service_length == '0))
    else $error("record on a failed request");

  // Empty remove reports zero occupancy
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sipq_pkg::ST_EMPTY) |-> (out_occupancy == '0))
    else $error("empty status with records stored");

  // Full insert reports full occupancy
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sipq_pkg::ST_FULL) |-> (out_occupancy == FULL_CNT[6:0]))
    else $error("full status below depth");

endmodule

bind sorted_insert_priority_queue sipq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sipq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_arrival_stamp  (out_arrival_stamp),
  .out_urgency        (out_urgency),
  .out_service_length (out_service_length),
  .out_occupancy      (out_occupancy)
);
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the sorted-insert priority queue.
`default_nettype none
module tb_top;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 10;

  // Expected outcome of one request
  typedef struct {
    logic [1:0]     status;
    sipq_pkg::rec_t rec;
    logic [6:0]     occupancy;
  } queue_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [15:0] in_arrival_stamp;
  logic [7:0]  in_urgency;
  logic [15:0] in_service_length;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [15:0] out_arrival_stamp;
  logic [7:0]  out_urgency;
  logic [15:0] out_service_length;
  logic [6:0]  out_occupancy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_order_mode;

  // Shadow of the queue and its ordering mode
  sipq_pkg::rec_t shadow_queue[$];
  logic           shadow_mode;
  queue_result_t  pending_results[$];

  int error_count;
  int idle_cycles;
  int sender_max_gap;
  int receiver_max_gap;
  int hold_request;
  int requests_seen;
  int records_removed;
  int full_drops;
  int empty_removes;

  sorted_insert_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_arrival_stamp  (in_arrival_stamp),
    .in_urgency        (in_urgency),
    .in_service_length (in_service_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_arrival_stamp (out_arrival_stamp),
    .out_urgency       (out_urgency),
    .out_service_length(out_service_length),
    .out_occupancy     (out_occupancy),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_order_mode    (cfg_order_mode)
  );

  // Generate the clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // True when the new record goes behind the stored one
  function automatic logic moves_ahead(input logic mode, input sipq_pkg::rec_t nw,
                                       input sipq_pkg::rec_t old);
    if (mode == sipq_pkg::MODE_STAMP) begin
      return nw.stamp < old.stamp;
    end
    if (nw.urg < old.urg) begin
      return 1'b1;
    end
    return (nw.urg == old.urg) && (nw.stamp < old.stamp);
  endfunction

  // Apply one request to the shadow queue and queue up its outcome
  function automatic void predict_request(input logic req, input sipq_pkg::rec_t rec);
    queue_result_t res;
    int pos;
    res.status = sipq_pkg::ST_OK;
    res.rec    = '0;
    if (req == sipq_pkg::REQ_INSERT) begin
      if (shadow_queue.size() >= QUEUE_DEPTH) begin
        res.status = sipq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_queue.size() && moves_ahead(shadow_mode, rec, shadow_queue[pos]))
          pos++;
        shadow_queue.insert(pos, rec);
      end
    end else begin
      if (shadow_queue.size() == 0) begin
        res.status = sipq_pkg::ST_EMPTY;
      end else begin
        res.rec = shadow_queue.pop_front();
        records_removed++;
      end
    end
    res.occupancy = 7'(shadow_queue.size());
    pending_results.push_back(res);
  endfunction

  // Compare one result transaction with the oldest expectation
  function automatic void check_result();
    queue_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("result with no request outstanding: status %0d occupancy %0d",
             out_status, out_occupancy);
      error_count++;
      return;
    end
    exp_res = pending_results.pop_front();
    if (out_status !== exp_res.status) begin
      $error("out_status expected %0d actual %0d", exp_res.status, out_status);
      error_count++;
    end
    if (out_arrival_stamp !== exp_res.rec.stamp) begin
      $error("out_arrival_stamp expected %0d actual %0d", exp_res.rec.stamp, out_arrival_stamp);
      error_count++;
    end
    if (out_urgency !== exp_res.rec.urg) begin
      $error("out_urgency expected %0d actual %0d", exp_res.rec.urg, out_urgency);
      error_count++;
    end
    if (out_service_length !== exp_res.rec.svc) begin
      $error("out_service_length expected %0d actual %0d", exp_res.rec.svc, out_service_length);
      error_count++;
    end
    if (out_occupancy !== exp_res.occupancy) begin
      $error("out_occupancy expected %0d actual %0d", exp_res.occupancy, out_occupancy);
      error_count++;
    end
    case (exp_res.status)
      sipq_pkg::ST_FULL:  full_drops++;
      sipq_pkg::ST_EMPTY: empty_removes++;
      default:            ;
    endcase
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk) begin : channel_monitor
    logic busy;
    sipq_pkg::rec_t rec;
    busy = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        shadow_mode = cfg_order_mode;
        busy = 1'b1;
      end
      if (in_valid && in_ready) begin
        rec.stamp = in_arrival_stamp;
        rec.urg   = in_urgency;
        rec.svc   = in_service_length;
        predict_request(in_req_type, rec);
        requests_seen++;
        busy = 1'b1;
      end
      if (out_valid && out_ready) begin
        check_result();
        busy = 1'b1;
      end
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
  end

  // End the run when nothing moves for too long
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d idle cycles, %0d results outstanding",
             idle_cycles, pending_results.size());
    $display("Verification failed");
    $finish;
  end

  // Drain results with random stalls and the occasional long hold-off
  initial begin : result_sink
    int stall;
    int hold;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      stall = $urandom_range(0, receiver_max_gap);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(input logic req, input sipq_pkg::rec_t rec);
    int gap;
    gap = $urandom_range(0, sender_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_arrival_stamp  <= rec.stamp;
    in_urgency        <= rec.urg;
    in_service_length <= rec.svc;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every outstanding result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write order_mode once the queue is idle
  task automatic set_order_mode(input logic mode);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_order_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic sipq_pkg::rec_t make_record(input logic [15:0] stamp,
                                                 input logic [7:0] urg,
                                                 input logic [15:0] svc);
    sipq_pkg::rec_t rec;
    rec.stamp = stamp;
    rec.urg   = urg;
    rec.svc   = svc;
    return rec;
  endfunction

  // Random record, biased toward ties and extremes
  function automatic sipq_pkg::rec_t random_record();
    sipq_pkg::rec_t rec;
    case ($urandom_range(0, 3))
      0:       rec.stamp = 16'($urandom_range(0, 7));
      1:       rec.stamp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: rec.stamp = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       rec.urg = 8'($urandom_range(0, 3));
      1:       rec.urg = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: rec.urg = 8'($urandom);
    endcase
    rec.svc = 16'($urandom);
    return rec;
  endfunction

  task automatic send_random(input int insert_pct);
    logic req;
    req = ($urandom_range(1, 100) <= insert_pct) ? sipq_pkg::REQ_INSERT : sipq_pkg::REQ_REMOVE;
    send_request(req, random_record());
  endtask

  // Remove from an empty queue right after reset
  task automatic test_empty_remove();
    send_request(sipq_pkg::REQ_REMOVE, random_record());
    drain_results();
  endtask

  // Urgency-then-stamp ordering, field extremes and equal records
  task automatic test_urgency_order();
    set_order_mode(sipq_pkg::MODE_URGENCY);
    send_request(sipq_pkg::REQ_INSERT, make_record(16'd100, 8'd5, 16'd0));
    send_request(sipq_pkg::REQ_INSERT, make_record(16'd200, 8'd5, 16'hFFFF));
    send_request(sipq_pkg::REQ_INSERT, make_record(16'd50, 8'd5, 16'd1));
    send_request(sipq_pkg::REQ_INSERT, make_record(16'hFFFF, 8'd0, 16'h8000));
    send_request(sipq_pkg::REQ_INSERT, make_record(16'h0000, 8'hFF, 16'h7FFF));
    // equal record goes in front of the stored one
    send_request(sipq_pkg::REQ_INSERT, make_record(16'd100, 8'd5, 16'd7));
    repeat (7) send_request(sipq_pkg::REQ_REMOVE, random_record());
    drain_results();
  endtask

  // Stamp-only ordering, with an equal stamp
  task automatic test_stamp_order();
    set_order_mode(sipq_pkg::MODE_STAMP);
    send_request(sipq_pkg::REQ_INSERT, make_record(16'd300, 8'd0, 16'd11));
    send_request(sipq_pkg::REQ_INSERT, make_record(16'd100, 8'hFF, 16'd22));
    send_request(sipq_pkg::REQ_INSERT, make_record(16'd300, 8'd9, 16'd33));
    send_request(sipq_pkg::REQ_INSERT, make_record(16'hFFFF, 8'd1, 16'd44));
    send_request(sipq_pkg::REQ_INSERT, make_record(16'h0000, 8'd2, 16'd55));
    repeat (5) send_request(sipq_pkg::REQ_REMOVE, random_record());
    drain_results();
  endtask

  // Fill the queue, overflow it, then empty it and remove twice more
  task automatic test_fill_overflow();
    set_order_mode(sipq_pkg::MODE_URGENCY);
    repeat (QUEUE_DEPTH + 3) send_request(sipq_pkg::REQ_INSERT, random_record());
    repeat (QUEUE_DEPTH + 2) send_request(sipq_pkg::REQ_REMOVE, random_record());
    drain_results();
  endtask

  // Random mixes across both modes, the insert share varying per phase
  task automatic test_random_mix();
    int insert_pct[8];
    int phase;
    insert_pct = '{70, 50, 30, 85, 55, 45, 65, 50};
    for (phase = 0; phase < 8; phase++) begin
      if (phase < 4)
        set_order_mode(phase[0] ? sipq_pkg::MODE_STAMP : sipq_pkg::MODE_URGENCY);
      else
        set_order_mode(1'($urandom_range(0, 1)));
      repeat (200) send_random(insert_pct[phase]);
    end
    drain_results();
  endtask

  // Hold the result side off so the block fills up and stalls its input
  task automatic test_backpressure();
    sender_max_gap = 0;
    hold_request   = 300;
    repeat (60) send_random(60);
    drain_results();
    sender_max_gap = 6;
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_no_idle();
    set_order_mode(sipq_pkg::MODE_STAMP);
    sender_max_gap   = 0;
    receiver_max_gap = 0;
    repeat (150) send_random(55);
    drain_results();
    sender_max_gap   = 6;
    receiver_max_gap = 6;
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_req_type       = sipq_pkg::REQ_INSERT;
    in_arrival_stamp  = '0;
    in_urgency        = '0;
    in_service_length = '0;
    cfg_valid         = 1'b0;
    cfg_order_mode    = sipq_pkg::MODE_URGENCY;
    shadow_mode       = sipq_pkg::MODE_URGENCY;
    error_count       = 0;
    idle_cycles       = 0;
    sender_max_gap    = 6;
    receiver_max_gap  = 6;
    hold_request      = 0;
    requests_seen     = 0;
    records_removed   = 0;
    full_drops        = 0;
    empty_removes     = 0;

    // Hold reset low, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_remove();
    test_urgency_order();
    test_stamp_order();
    test_fill_overflow();
    test_random_mix();
    test_backpressure();
    test_no_idle();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("Covered %0d requests in both order modes: %0d head removals, %0d dropped inserts,",
             requests_seen, records_removed, full_drops);
    $display("%0d removes on an empty queue, long output hold-off and back-to-back traffic",
             empty_removes);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sorted_insert_priority_queue.f
design/sipq_pkg.sv
design/sipq_cell.sv
design/sipq_ctrl.sv
design/sorted_insert_priority_queue.sv
design/sipq_checker.sv
verif/tb_top.sv
